FILE: rtl/wps_pkg.sv
// Shared types and constants for the weighted permutation sampler.
// Used by wps_ctrl, wps_dp and weighted_permutation_sampler; no dependencies.
`default_nettype none

package wps_pkg;

    localparam int FRAC_W  = 16;
    localparam int SLOT_W  = 5;
    localparam int WIN_W   = 16;
    localparam int ELEM_W  = 5;
    localparam int POS_W   = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_END,
        ST_MUL,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic wr;
        logic rd;
        logic rd_scan;
        logic mul;
        logic clr_cnt;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cnt_last;
        logic mul_last;
        logic done;
    } t_ctrl_sts;

endpackage

`default_nettype wire

FILE: rtl/weighted_permutation_sampler.sv
// Weighted permutation sampler: draws a permutation by weighted roulette
// selection without replacement. Depends on wps_pkg, wps_ctrl and wps_dp.
//
// Input channel (i_valid / o_stall): op 0 writes i_weight_value to weight slot
// i_slot (slots at or above ELEMENTS are dropped). Op 1 draws the next element
// of the permutation and returns one result transfer.
// Output channel (o_valid / i_stall): element, position in the permutation,
// and last, set on the draw that fills the final position.
// A draw runs through: a pass over the weight memory for the unplaced total,
// a bit-serial threshold multiply, and a running-sum scan of the memory (ends
// after the hit or at the last element), then the output state. The next input
// is taken in the cycle after the result transfer, bounded by the single read
// port of the weight memory. One item is in flight at a time; o_stall stays high
// from acceptance of a draw until the result transfer.
// While i_stall is high the result holds on the output and no input is taken.
// Reset clears all weights to zero, the placed marks and the position.
`default_nettype none

module weighted_permutation_sampler #(
    parameter int ELEMENTS    = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_op,
    input  wire [wps_pkg::SLOT_W-1:0]   i_slot,
    input  wire [wps_pkg::WIN_W-1:0]    i_weight_value,
    input  wire [wps_pkg::FRAC_W-1:0]   i_fraction,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [wps_pkg::ELEM_W-1:0]  o_element,
    output logic [wps_pkg::POS_W-1:0]   o_position,
    output logic                        o_last
);

    wps_pkg::t_ctrl_cmd cmd;
    wps_pkg::t_ctrl_sts sts;

    wps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_stall     (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    wps_dp #(
        .ELEMENTS    (ELEMENTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_slot         (i_slot),
        .i_weight_value (i_weight_value),
        .i_fraction     (i_fraction),
        .o_sts          (sts),
        .o_element      (o_element),
        .o_position     (o_position),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

FILE: rtl/wps_ctrl.sv
// Sequencer for the sampler: handshakes and draw phases (sum, multiply, scan).
// Depends on wps_pkg.
`default_nettype none

module wps_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  i_op,
    input  wire                  i_stall,
    input  wire wps_pkg::t_ctrl_sts i_sts,
    output wps_pkg::t_ctrl_cmd   o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);

    wps_pkg::t_state r_state;
    wps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wps_pkg::ST_IDLE: begin
                if (i_valid && (i_op == wps_pkg::OP_DRAW)) begin
                    n_state = wps_pkg::ST_SUM;
                end
            end
            wps_pkg::ST_SUM: begin
                if (i_sts.cnt_last) begin
                    n_state = wps_pkg::ST_SUM_END;
                end
            end
            wps_pkg::ST_SUM_END: begin
                n_state = wps_pkg::ST_MUL;
            end
            wps_pkg::ST_MUL: begin
                if (i_sts.mul_last) begin
                    n_state = wps_pkg::ST_SCAN;
                end
            end
            wps_pkg::ST_SCAN: begin
                if (i_sts.done) begin
                    n_state = wps_pkg::ST_OUT;
                end else if (i_sts.cnt_last) begin
                    n_state = wps_pkg::ST_SCAN_WAIT;
                end
            end
            wps_pkg::ST_SCAN_WAIT: begin
                if (i_sts.done) begin
                    n_state = wps_pkg::ST_OUT;
                end
            end
            wps_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_state = wps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            wps_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.wr    = i_valid && (i_op == wps_pkg::OP_LOAD);
                o_cmd.start = i_valid && (i_op == wps_pkg::OP_DRAW);
            end
            wps_pkg::ST_SUM: begin
                o_cmd.rd = 1'b1;
            end
            wps_pkg::ST_SUM_END: begin
                o_cmd.clr_cnt = 1'b1;
            end
            wps_pkg::ST_MUL: begin
                o_cmd.mul     = 1'b1;
                o_cmd.clr_cnt = i_sts.mul_last;
            end
            wps_pkg::ST_SCAN: begin
                o_cmd.rd      = !i_sts.done;
                o_cmd.rd_scan = !i_sts.done;
            end
            wps_pkg::ST_SCAN_WAIT: begin
            end
            wps_pkg::ST_OUT: begin
                o_out_valid  = 1'b1;
                o_cmd.commit = !i_stall;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/wps_dp.sv
// Datapath for the sampler: weight memory, placed mask, total, serial threshold
// multiply and running-sum search. Depends on wps_pkg.
`default_nettype none

module wps_dp #(
    parameter int ELEMENTS    = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire wps_pkg::t_ctrl_cmd      i_cmd,
    input  wire [wps_pkg::SLOT_W-1:0]    i_slot,
    input  wire [wps_pkg::WIN_W-1:0]     i_weight_value,
    input  wire [wps_pkg::FRAC_W-1:0]    i_fraction,
    output wps_pkg::t_ctrl_sts           o_sts,
    output logic [wps_pkg::ELEM_W-1:0]   o_element,
    output logic [wps_pkg::POS_W-1:0]    o_position,
    output logic                         o_last
);

    localparam int IDX_W  = $clog2(ELEMENTS);
    localparam int MCNT_W = $clog2(wps_pkg::FRAC_W);
    localparam int CNT_W  = (IDX_W > MCNT_W) ? IDX_W : MCNT_W;
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;
    localparam int PROD_W = SUM_W + wps_pkg::FRAC_W;

    logic [WEIGHT_BITS-1:0] mem [ELEMENTS];
    logic [ELEMENTS-1:0]    r_wvld;
    logic [WEIGHT_BITS-1:0] r_rdata;
    logic                   r_rdata_ok;
    logic                   r_rdv;
    logic                   r_rd_scan;
    logic [IDX_W-1:0]       r_ridx;

    logic [CNT_W-1:0]          r_cnt;
    logic [ELEMENTS-1:0]       r_placed;
    logic [IDX_W-1:0]          r_pos;
    logic [IDX_W-1:0]          r_pick;
    logic [wps_pkg::FRAC_W-1:0] r_frac;
    logic [SUM_W-1:0]          r_total;
    logic [SUM_W-1:0]          r_acc;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_done;

    logic [IDX_W-1:0]       wr_addr;
    logic                   slot_ok;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic                   rd_free;
    logic [SUM_W-1:0]       acc_sum;
    logic                   hit;
    logic                   pos_last;

    assign wr_addr  = IDX_W'(i_slot);
    assign slot_ok  = 32'(i_slot) < 32'(ELEMENTS);
    assign rd_w     = r_rdata_ok ? r_rdata : '0;
    assign rd_free  = !r_placed[r_ridx];
    assign acc_sum  = r_acc + SUM_W'(rd_w);
    assign hit      = {acc_sum, {wps_pkg::FRAC_W{1'b0}}} >= r_prod;
    assign pos_last = r_pos == IDX_W'(ELEMENTS - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && slot_ok) begin
            mem[wr_addr] <= WEIGHT_BITS'(i_weight_value);
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld     <= '0;
            r_rdata_ok <= 1'b0;
            r_rdv      <= 1'b0;
            r_rd_scan  <= 1'b0;
            r_ridx     <= '0;
            r_cnt      <= '0;
            r_placed   <= '0;
            r_pos      <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cmd.wr && slot_ok) begin
                r_wvld[wr_addr] <= 1'b1;
            end
            r_rdv     <= i_cmd.rd;
            r_rd_scan <= i_cmd.rd_scan;
            if (i_cmd.rd) begin
                r_rdata_ok <= r_wvld[r_cnt[IDX_W-1:0]];
                r_ridx     <= r_cnt[IDX_W-1:0];
            end
            if (i_cmd.start || i_cmd.clr_cnt) begin
                r_cnt <= '0;
            end else if (i_cmd.rd || i_cmd.mul) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.start) begin
                r_done <= 1'b0;
            end else if (r_rdv && r_rd_scan && !r_done) begin
                if ((rd_free && hit) || (r_ridx == IDX_W'(ELEMENTS - 1))) begin
                    r_done <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (pos_last) begin
                    r_placed <= '0;
                    r_pos    <= '0;
                end else begin
                    r_placed[r_pick] <= 1'b1;
                    r_pos            <= r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_frac  <= i_fraction;
            r_total <= '0;
            r_acc   <= '0;
            r_prod  <= '0;
            r_pick  <= '0;
        end else begin
            if (r_rdv && !r_rd_scan && rd_free) begin
                r_total <= r_total + SUM_W'(rd_w);
            end
            if (i_cmd.mul) begin
                r_prod <= {r_prod[PROD_W-2:0], 1'b0}
                          + (r_frac[wps_pkg::FRAC_W-1] ? PROD_W'(r_total) : '0);
                r_frac <= {r_frac[wps_pkg::FRAC_W-2:0], 1'b0};
            end
            if (r_rdv && r_rd_scan && !r_done && rd_free) begin
                r_acc  <= acc_sum;
                r_pick <= r_ridx;
            end
        end
    end

    assign o_sts.cnt_last = r_cnt == CNT_W'(ELEMENTS - 1);
    assign o_sts.mul_last = r_cnt == CNT_W'(wps_pkg::FRAC_W - 1);
    assign o_sts.done     = r_done;

    assign o_element  = wps_pkg::ELEM_W'(r_pick);
    assign o_position = wps_pkg::POS_W'(r_pos);
    assign o_last     = pos_last;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for weighted_permutation_sampler: random weight loads
// and draws against an in-bench roulette predictor with random idles and stalls.
// Depends on wps_pkg and the RTL of weighted_permutation_sampler.

module tb_top;

    import wps_pkg::*;

    localparam int N_ELEM       = 32;
    localparam int N_ITEMS      = 1900;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct {
        logic [ELEM_W-1:0] element;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_draw_result;

    class permutation_scoreboard;
        logic [WIN_W-1:0]  weights [N_ELEM];
        logic [N_ELEM-1:0] placed;
        logic [POS_W-1:0]  next_pos;
        t_draw_result      pending_draws [$];
        int                errors;

        function new();
            foreach (weights[i]) weights[i] = '0;
            placed   = '0;
            next_pos = '0;
            errors   = 0;
        endfunction

        // Loads update the table; draws compute the roulette pick and advance
        // the permutation.
        function void note_input(logic op, logic [SLOT_W-1:0] slot,
                                 logic [WIN_W-1:0] wv, logic [FRAC_W-1:0] frac);
            logic [63:0]  total;
            logic [63:0]  acc;
            logic [63:0]  thr;
            int           pick;
            bit           hit;
            t_draw_result res;
            if (op == OP_LOAD) begin
                if (slot < N_ELEM)
                    weights[slot] = wv;
                return;
            end
            total = '0;
            for (int i = 0; i < N_ELEM; i++)
                if (!placed[i])
                    total += 64'(weights[i]);
            thr  = {48'b0, frac} * total;
            acc  = '0;
            pick = 0;
            hit  = 1'b0;
            for (int i = 0; i < N_ELEM; i++) begin
                if (!placed[i] && !hit) begin
                    pick = i;
                    acc += 64'(weights[i]);
                    if ((acc << 16) >= thr)
                        hit = 1'b1;
                end
            end
            res.element  = pick[ELEM_W-1:0];
            res.position = next_pos;
            res.last     = (next_pos == N_ELEM - 1);
            pending_draws.push_back(res);
            if (res.last) begin
                placed   = '0;
                next_pos = '0;
            end else begin
                placed[pick] = 1'b1;
                next_pos     = next_pos + 1'b1;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR: %s", msg);
        endtask

        task check_result(logic [ELEM_W-1:0] element, logic [POS_W-1:0] position,
                          logic last);
            t_draw_result exp_res;
            if (pending_draws.size() == 0) begin
                report($sformatf("result with nothing pending: element %0d position %0d",
                                 element, position));
                return;
            end
            exp_res = pending_draws.pop_front();
            if (element !== exp_res.element)
                report($sformatf("element %0d, predicted %0d (position %0d)",
                                 element, exp_res.element, exp_res.position));
            if (position !== exp_res.position)
                report($sformatf("position %0d, predicted %0d",
                                 position, exp_res.position));
            if (last !== exp_res.last)
                report($sformatf("last %0b, predicted %0b (position %0d)",
                                 last, exp_res.last, exp_res.position));
        endtask
    endclass

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              i_op           = OP_LOAD;
    logic [SLOT_W-1:0] i_slot         = '0;
    logic [WIN_W-1:0]  i_weight_value = '0;
    logic [FRAC_W-1:0] i_fraction     = '0;
    logic              i_stall        = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [ELEM_W-1:0] o_element;
    logic [POS_W-1:0]  o_position;
    logic              o_last;

    permutation_scoreboard sb;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycles      = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int run_left    = 0;

    weighted_permutation_sampler #(
        .ELEMENTS    (N_ELEM),
        .WEIGHT_BITS (16)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_weight_value (i_weight_value),
        .i_fraction     (i_fraction),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_element      (o_element),
        .o_position     (o_position),
        .o_last         (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall == 1'b0)
                sb.check_result(o_element, o_position, o_last);
            if (i_valid && o_stall === 1'b0)
                sb.note_input(i_op, i_slot, i_weight_value, i_fraction);
        end
    end

    // result-side backpressure: modes of free flow, random, long runs, heavy
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            2: begin
                if (run_left == 0) begin
                    i_stall  <= ~i_stall;
                    run_left <= $urandom_range(0, 25);
                end else begin
                    run_left <= run_left - 1;
                end
            end
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // entered and left at a falling edge; holds the payload while stalled
    task send(logic op, logic [SLOT_W-1:0] slot, logic [WIN_W-1:0] wv,
              logic [FRAC_W-1:0] frac);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_slot         <= slot;
        i_weight_value <= wv;
        i_fraction     <= frac;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task load_weight(logic [SLOT_W-1:0] slot, logic [WIN_W-1:0] wv);
        send(OP_LOAD, slot, wv, FRAC_W'($urandom));
    endtask

    task draw(logic [FRAC_W-1:0] frac);
        send(OP_DRAW, SLOT_W'($urandom), WIN_W'($urandom), frac);
    endtask

    function logic [WIN_W-1:0] pick_weight(int style);
        case (style)
            0: return WIN_W'($urandom);
            1: return WIN_W'($urandom_range(0, 15));
            2: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return '0;
        endcase
    endfunction

    initial begin
        int style;
        int n;
        logic [FRAC_W-1:0] frac;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all weights zero: first unplaced element wins
        draw(16'h0000);
        draw(16'hFFFF);
        load_weight(5'd31, 16'hFFFF);
        load_weight(5'd0, 16'h0000);
        load_weight(5'd5, 16'h0001);
        draw(16'hFFFF);
        draw(16'h0000);
        // writes to placed and unplaced slots mid-permutation
        load_weight(5'd31, 16'h0000);
        load_weight(5'd7, 16'hFFFF);
        load_weight(5'd10, 16'h5555);
        load_weight(5'd21, 16'hAAAA);
        draw(16'h8000);
        draw(16'h0001);
        draw(16'hFFFE);
        draw(16'h5555);
        draw(16'hAAAA);

        while (items_sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    style = $urandom_range(0, 3);
                    n     = $urandom_range(1, 8);
                    repeat (n) load_weight(SLOT_W'($urandom), pick_weight(style));
                end
                2: begin
                    style = $urandom_range(0, 3);
                    for (int s = 0; s < N_ELEM; s++)
                        load_weight(SLOT_W'(s), ($urandom_range(0, 5) == 0) ?
                                    pick_weight($urandom_range(0, 3)) :
                                    pick_weight(style));
                end
                default: begin
                    n = $urandom_range(1, 40);
                    repeat (n) begin
                        if ($urandom_range(0, 11) == 0) begin
                            load_weight(SLOT_W'($urandom),
                                        pick_weight($urandom_range(0, 2)));
                        end else begin
                            case ($urandom_range(0, 9))
                                0: frac = '0;
                                1: frac = '1;
                                default: frac = FRAC_W'($urandom);
                            endcase
                            draw(frac);
                        end
                    end
                end
            endcase
        end
        i_valid <= 1'b0;

        while (sb.pending_draws.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_draws.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/wps_pkg.sv
rtl/wps_ctrl.sv
rtl/wps_dp.sv
rtl/weighted_permutation_sampler.sv
tb/tb_top.sv
